/* src/leaky_recursive_running_sum_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the leaky recursive running sum unit
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef LEAKY_RECURSIVE_RUNNING_SUM_UNIT_MACROS_SVH
`define LEAKY_RECURSIVE_RUNNING_SUM_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define LRRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define LRRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lrrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrrs_pkg
// Widths, delay capacity, fixed-point shift, register reset values and register
// indexes of the leaky recursive running sum unit.
// ----------------------------------------------------------------------------
package lrrs_pkg;

   // Sample, result, gain and delay length widths
   localparam int SAMPLE_W = 24;
   localparam int RESULT_W = 32;
   localparam int GAIN_W   = 16;
   localparam int DLEN_W   = 11;

   // Configuration port widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Default delay line capacity
   localparam int MAX_DELAY_DEFAULT = 1024;

   // Register reset values
   localparam logic [GAIN_W-1:0] DECAY_FACTOR_RST    = 16'd65208;
   localparam logic [GAIN_W-1:0] DECAY_POW_DELAY_RST = 16'd47942;
   localparam logic [DLEN_W-1:0] DELAY_LENGTH_RST    = 11'd64;

   // Fixed-point layout: samples are scaled by 2^FRAC_SHIFT before summing
   localparam int FRAC_SHIFT = 16;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECAY_FACTOR    = 2'd0,
      CSR_DECAY_POW_DELAY = 2'd1,
      CSR_DELAY_LENGTH    = 2'd2
   } csr_index_type;

endpackage

/* src/leaky_recursive_running_sum_unit.sv */
// Pipeline: history read into hist_rd_ff, delayed term into s2_term_ff, then
// feedback multiply-add with rounding and saturation into y_ff. Throughput:
// one item per cycle unless the output stalls; the y[n-1] multiply-add loop
// closes in the last stage; the delay line memory takes one write and one read.
// Reset: clears the pipeline, the history pointer, the fill flag and y[n-1];
// the delay line is not swept, unwritten slots read as zero through the fill flag.
// ----------------------------------------------------------------------------
// leaky_recursive_running_sum_unit
// Leaky recursive running sum: y = x - cM*x[n-M] + c*y[n-1], Q9.23 saturated,
// with the input history kept in a single-port-write, one-read delay memory.
// ----------------------------------------------------------------------------
`include "leaky_recursive_running_sum_unit_macros.svh"

module leaky_recursive_running_sum_unit #(
   parameter int MAX_DELAY = lrrs_pkg::MAX_DELAY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream: [23:0] sample_in
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic signed [lrrs_pkg::SAMPLE_W-1:0]  req_tdata,
   // result stream: [31:0] sample_out
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [lrrs_pkg::RESULT_W-1:0]  rsp_tdata,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lrrs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lrrs_pkg::CSR_DATA_W-1:0]       csr_data
);
   import lrrs_pkg::*;

   localparam int PTR_W  = $clog2(MAX_DELAY);
   localparam int M_W    = $clog2(MAX_DELAY + 1);
   localparam int DIFF_W = M_W + 1;
   localparam int PROD1_W = SAMPLE_W + GAIN_W + 1;
   localparam int TERM_W  = SAMPLE_W + FRAC_SHIFT + 2;
   localparam int PROD2_W = RESULT_W + GAIN_W + 1;
   localparam int ACC_W   = PROD2_W + 1;
   localparam int RND_W   = ACC_W - FRAC_SHIFT;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [GAIN_W-1:0] decay_factor_ff, decay_factor_in;
   logic [GAIN_W-1:0] decay_pow_ff, decay_pow_in;
   logic [DLEN_W-1:0] delay_len_ff, delay_len_in;
   logic              csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Decode register writes; indexes beyond the list are dropped
   always_comb begin
      decay_factor_in = decay_factor_ff;
      decay_pow_in    = decay_pow_ff;
      delay_len_in    = delay_len_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_DECAY_FACTOR:    decay_factor_in = csr_data;
            CSR_DECAY_POW_DELAY: decay_pow_in    = csr_data;
            CSR_DELAY_LENGTH:    delay_len_in    = csr_data[DLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_factor_ff <= DECAY_FACTOR_RST;
         decay_pow_ff    <= DECAY_POW_DELAY_RST;
         delay_len_ff    <= DELAY_LENGTH_RST;
      end else begin
         decay_factor_ff <= decay_factor_in;
         decay_pow_ff    <= decay_pow_in;
         delay_len_ff    <= delay_len_in;
      end
   end

   // Clamp the delay length into 1..MAX_DELAY
   logic [M_W-1:0] delay_eff;
   always_comb begin
      if (delay_len_ff == '0) begin
         delay_eff = M_W'(1);
      end else if (32'(delay_len_ff) > 32'(MAX_DELAY)) begin
         delay_eff = M_W'(MAX_DELAY);
      end else begin
         delay_eff = M_W'(delay_len_ff);
      end
   end

   // ------------------------------------------------------------------
   // Pipeline handshake: each stage moves when the next is empty or moving
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s3_ready, s2_ready, s1_ready;
   logic s2_fire, s1_fire, req_fire;

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_fire    = s2_valid_ff && s3_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_fire    = s1_valid_ff && s2_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);
   assign s2_valid_in = s1_fire  || (s2_valid_ff && !s2_fire);
   assign s3_valid_in = s2_fire  || (s3_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: write pointer, fill flag, delayed read address
   // ------------------------------------------------------------------
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              wrapped_ff, wrapped_in;
   logic              ptr_last;
   logic [DIFF_W-1:0] rd_diff;
   logic [PTR_W-1:0]  rd_addr;
   logic              rd_written;

   assign ptr_last = (ptr_ff == PTR_W'(MAX_DELAY - 1));

   // Advance the pointer on each accepted item, wrap at capacity
   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      if (req_fire) begin
         if (ptr_last) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // Read slot M items back, modulo capacity
   assign rd_diff = DIFF_W'(ptr_ff) - DIFF_W'(delay_eff);
   assign rd_addr = rd_diff[DIFF_W-1] ? PTR_W'(rd_diff + DIFF_W'(MAX_DELAY))
                                      : PTR_W'(rd_diff);

   // Slots are filled in order from zero, so a slot is written once it lies
   // below the pointer or the pointer has wrapped
   assign rd_written = wrapped_ff || (rd_addr < ptr_ff);

   // Delay line memory: read-before-write, so a full-length delay reads the
   // sample that the current item overwrites
   logic signed [SAMPLE_W-1:0] hist_mem [MAX_DELAY];
   logic signed [SAMPLE_W-1:0] hist_rd_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hist_mem[ptr_ff] <= req_tdata;
         hist_rd_ff       <= hist_mem[rd_addr];
      end
   end

   // Hold the sample and the fill status next to the memory read
   logic signed [SAMPLE_W-1:0] s1_x_ff;
   logic                       s1_written_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff       <= req_tdata;
         s1_written_ff <= rd_written;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: feed-forward term x*2^16 - cM*x[n-M]
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] s1_hist;
   logic signed [GAIN_W:0]     pow_s;
   logic signed [PROD1_W-1:0] s1_prod;
   logic signed [TERM_W-1:0]  s1_term;
   logic signed [TERM_W-1:0]  s2_term_ff;

   assign s1_hist = s1_written_ff ? hist_rd_ff : '0;
   assign pow_s   = signed'({1'b0, decay_pow_ff});
   assign s1_prod = s1_hist * pow_s;
   assign s1_term = TERM_W'(signed'({s1_x_ff, {FRAC_SHIFT{1'b0}}})) - TERM_W'(s1_prod);

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_term_ff <= s1_term;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: feedback c*y[n-1], round half up, saturate
   // ------------------------------------------------------------------
   logic signed [RESULT_W-1:0] y_ff, y_in;
   logic signed [GAIN_W:0]     factor_s;
   logic signed [PROD2_W-1:0] s2_prod;
   logic signed [ACC_W-1:0]   s2_acc;
   logic signed [RND_W-1:0]   s2_rnd;
   logic                      s2_fits;

   assign factor_s = signed'({1'b0, decay_factor_ff});
   assign s2_prod  = y_ff * factor_s;
   assign s2_acc   = ACC_W'(s2_term_ff) + ACC_W'(s2_prod)
                   + ACC_W'(1 << (FRAC_SHIFT - 1));
   assign s2_rnd   = s2_acc[ACC_W-1:FRAC_SHIFT];

   // Fits when the bits above the result sign all match it
   assign s2_fits = (s2_rnd[RND_W-1:RESULT_W-1] == '0)
                 || (s2_rnd[RND_W-1:RESULT_W-1] == '1);

   always_comb begin
      y_in = y_ff;
      if (s2_fire) begin
         if (s2_fits) begin
            y_in = s2_rnd[RESULT_W-1:0];
         end else if (s2_rnd[RND_W-1]) begin
            y_in = {1'b1, {(RESULT_W-1){1'b0}}};
         end else begin
            y_in = {1'b0, {(RESULT_W-1){1'b1}}};
         end
      end
   end

   // y[n-1] doubles as the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff <= '0;
      end else begin
         y_ff <= y_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = y_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `LRRS_ASSERT_NEXT(a_ptr_wrap, clock, reset, req_fire && ptr_last,
      wrapped_ff && (ptr_ff == '0), "pointer did not wrap to zero at capacity")
   `LRRS_ASSERT_NOW(a_rd_ne_wr, clock, reset, req_fire && (rd_addr == ptr_ff),
      delay_eff == M_W'(MAX_DELAY), "delayed read hits the write slot below full delay")
   `LRRS_ASSERT_NEXT(a_result_shown, clock, reset, s2_fire, rsp_tvalid,
      "finished result not presented")
   `LRRS_ASSERT_NOW(a_unfilled_ptr, clock, reset, !wrapped_ff,
      !(req_fire && ptr_last && (rd_addr < ptr_ff) && (delay_eff == M_W'(MAX_DELAY))),
      "full delay read before first wrap marked as written")

endmodule

/* tb/sv/leaky_recursive_running_sum_unit_tb.sv */
// ----------------------------------------------------------------------------
// leaky_recursive_running_sum_unit_tb
// Streams signed samples through the leaky recursive running sum unit and
// compares every filtered sample against an in-bench predictor of the filter
// (delay line, feedback term, round half up, saturation). Covers default
// gains, gain extremes, delay length clamping and masking, changes of the
// delay while the line holds data, long result stalls, random traffic and
// saturation at both ends of the output range.
// ----------------------------------------------------------------------------
module leaky_recursive_running_sum_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrrs_pkg::*;

   localparam int DEPTH       = MAX_DELAY_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [CSR_IDX_W-1:0]       CSR_SPARE_INDEX = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX      = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN      = 24'sh800000;
   localparam longint                     OUT_MAX         = 64'sd2147483647;
   localparam longint                     OUT_MIN         = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic signed [SAMPLE_W-1:0]   req_tdata  = '0;   // [23:0] sample_in
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic signed [RESULT_W-1:0]   rsp_tdata;          // [31:0] sample_out
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index  = '0;
   logic [CSR_DATA_W-1:0]        csr_data   = '0;

   // Predictor state: registers, delay line, pointer and y[n-1]
   logic [GAIN_W-1:0]            gain_feedback = DECAY_FACTOR_RST;
   logic [GAIN_W-1:0]            gain_delayed  = DECAY_POW_DELAY_RST;
   logic [DLEN_W-1:0]            delay_reg     = DELAY_LENGTH_RST;
   logic signed [SAMPLE_W-1:0]   sample_line [DEPTH] = '{default: '0};
   int unsigned                  line_ptr      = 0;
   logic signed [RESULT_W-1:0]   last_output   = '0;

   logic signed [RESULT_W-1:0]   expected_samples [$];
   int                           error_count   = 0;
   int                           cycle_count   = 0;

   // Idling controls shared by the stimulus and the result side
   bit feed_gaps     = 1'b1;
   bit drain_gaps    = 1'b1;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int ready_gap     = 0;

   leaky_recursive_running_sum_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Abort a run that stops making progress
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("leaky_recursive_running_sum_unit_tb: errors");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1:       return '1;
         2, 3:    return GAIN_W'($urandom_range(60000, 65535));
         default: return GAIN_W'($urandom());
      endcase
   endfunction

   // Filter one sample: exact Q.39 sum, round half up to Q.23, saturate
   function automatic logic signed [RESULT_W-1:0] filter_step(
      input logic signed [SAMPLE_W-1:0] x);
      int unsigned eff_delay;
      int unsigned tap;
      longint      delayed;
      longint      fb_gain;
      longint      dl_gain;
      longint      acc;
      longint      y;
      eff_delay = (delay_reg == 0) ? 1 : ((delay_reg > DEPTH) ? DEPTH : delay_reg);
      tap       = (line_ptr >= eff_delay) ? line_ptr - eff_delay
                                          : line_ptr + DEPTH - eff_delay;
      delayed   = sample_line[tap];
      fb_gain   = gain_feedback;
      dl_gain   = gain_delayed;
      acc = (longint'(x) <<< FRAC_SHIFT) - delayed * dl_gain
          + longint'(last_output) * fb_gain;
      y = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (y > OUT_MAX)
         y = OUT_MAX;
      if (y < OUT_MIN)
         y = OUT_MIN;
      sample_line[line_ptr] = x;
      line_ptr    = (line_ptr + 1 >= DEPTH) ? 0 : line_ptr + 1;
      last_output = RESULT_W'(y);
      return last_output;
   endfunction

   // Offer one sample, hold it until taken, then record its filtered value
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      int gap;
      gap = feed_gaps ? idle_length() : 0;
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(filter_step(x));
   endtask

   // Write a register once every pending result has come back
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DECAY_FACTOR:    gain_feedback = value;
         CSR_DECAY_POW_DELAY: gain_delayed  = value;
         CSR_DELAY_LENGTH:    delay_reg     = value[DLEN_W-1:0];
         default:             ;
      endcase
   endtask

   // Drive result ready: long hold on request, otherwise random gaps
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap  = ready_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         ready_gap  = drain_gaps ? idle_length() : 0;
      end
   end

   // Compare each accepted result with the oldest pending filtered sample
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: sample_out %0d", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== expected_samples[0]) begin
               if (error_count < 10)
                  $display("sample_out mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                           expected_samples[0], expected_samples[0], rsp_tdata,
                           rsp_tdata);
               error_count++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   // Reset gains, empty delay line, full-scale and small samples
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample('0);
      send_sample(24'sd1);
   endtask

   // Gains at both ends with the shortest delay
   task automatic test_gain_extremes();
      write_register(CSR_DECAY_FACTOR, '1);
      write_register(CSR_DECAY_POW_DELAY, '1);
      write_register(CSR_DELAY_LENGTH, 16'd1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(-24'sd1);
      write_register(CSR_DECAY_FACTOR, '0);
      write_register(CSR_DECAY_POW_DELAY, '0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   // Zero delay, delay above capacity, masked upper bits, spare index,
   // delay changed over a line that already holds data
   task automatic test_delay_special_cases();
      write_register(CSR_DECAY_FACTOR, 16'd32768);
      write_register(CSR_DECAY_POW_DELAY, 16'd40000);
      write_register(CSR_DELAY_LENGTH, 16'd0);
      send_sample(24'sd1000000);
      send_sample(-24'sd777);
      write_register(CSR_DELAY_LENGTH, 16'hFFFF);
      send_sample(24'sd4242);
      write_register(CSR_DELAY_LENGTH, 16'd1025);
      send_sample(-24'sd99999);
      write_register(CSR_SPARE_INDEX, 16'd5);
      send_sample(24'sd123456);
      write_register(CSR_DELAY_LENGTH, 16'd3);
      send_sample(SAMPLE_MAX);
      send_sample(24'sd2000000);
      send_sample(SAMPLE_MIN);
      write_register(CSR_DELAY_LENGTH, 16'd2);
      send_sample(24'sd17);
      send_sample(-24'sd3000000);
   endtask

   // Hold the result side while samples keep coming, so the input stalls
   task automatic test_backpressure();
      feed_gaps = 1'b0;
      hold_requests++;
      repeat (48) send_sample(24'($urandom()));
      feed_gaps = 1'b1;
   endtask

   // Random gains and delays per phase, mixed sample content
   task automatic test_random_traffic();
      int                         r;
      logic [CSR_DATA_W-1:0]      dlen;
      logic signed [SAMPLE_W-1:0] x;
      repeat (4) begin
         feed_gaps  = ($urandom_range(0, 3) != 0);
         drain_gaps = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 19);
         case (r)
            0:       dlen = '0;
            1:       dlen = 16'd1024;
            2:       dlen = 16'($urandom_range(1025, 2047));
            3:       dlen = {5'($urandom()), 11'($urandom_range(1, 16))};
            4, 5, 6, 7, 8, 9, 10, 11:
                     dlen = 16'($urandom_range(1, 8));
            default: dlen = 16'($urandom_range(9, 200));
         endcase
         write_register(CSR_DECAY_FACTOR, random_gain());
         write_register(CSR_DECAY_POW_DELAY, random_gain());
         write_register(CSR_DELAY_LENGTH, dlen);
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_SPARE_INDEX, 16'($urandom()));
         repeat (30) begin
            r = $urandom_range(0, 99);
            if (r < 60)
               x = 24'($urandom());
            else if (r < 80)
               x = 24'(int'($urandom_range(0, 511)) - 256);
            else
               case ($urandom_range(0, 4))
                  0:       x = SAMPLE_MAX;
                  1:       x = SAMPLE_MIN;
                  2:       x = '0;
                  3:       x = -24'sd1;
                  default: x = 24'sd1;
               endcase
            send_sample(x);
         end
      end
      feed_gaps  = 1'b1;
      drain_gaps = 1'b1;
   endtask

   // Drive the sum into the upper limit, then cancel the window into the lower
   task automatic test_saturation();
      write_register(CSR_DECAY_FACTOR, '0);
      write_register(CSR_DECAY_POW_DELAY, '0);
      write_register(CSR_DELAY_LENGTH, 16'd1);
      send_sample(SAMPLE_MAX - 24'($urandom_range(0, 4095)));
      write_register(CSR_DECAY_FACTOR, '1);
      repeat (279) send_sample(SAMPLE_MAX - 24'($urandom_range(0, 4095)));
      write_register(CSR_DECAY_POW_DELAY, '1);
      write_register(CSR_DELAY_LENGTH, 16'd280);
      repeat (270) send_sample(SAMPLE_MIN + 24'($urandom_range(0, 4095)));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_gain_extremes();
      test_delay_special_cases();
      test_backpressure();
      test_random_traffic();
      test_saturation();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      // catch any stray result after the last one
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("leaky_recursive_running_sum_unit_tb: clean");
      else
         $display("leaky_recursive_running_sum_unit_tb: errors");
      $finish;
   end

endmodule
